// File: sv/rhc_pkg.sv
// Shared constants and types for the RGB/HSL color converter.
`default_nettype none
package rhc_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int FIELD_W       = 13;
    localparam int DATA_W        = 40;
    localparam int DIV_W         = 14;
    localparam int HUE_TURN      = 5760;
    localparam int HUE_SIXTH     = 960;

    typedef enum logic {
        OP_RGB2HSL = 1'b0,
        OP_HSL2RGB = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sec_t;

endpackage
`default_nettype wire

// File: sv/rgb_hsl_color_converter.sv
// Top level of the RGB/HSL color converter: front stages, two dividers, output skid.
`default_nettype none
// This block converts one color per beat, either RGB to HSL or HSL to RGB as s_tuser
// selects. Channels, saturation and lightness are unsigned fixed point where
// 2**FRAC_BITS means 1.0, and hue is in sixteenths of a degree (0 to 5759). Every
// quotient is rounded to nearest with ties going up. The block takes one beat in every
// clock cycle and keeps taking beats while a finished result waits on the master side,
// since a skid register sits behind the output register. The pipeline depth is set by
// the two bit-serial dividers for saturation and hue, which retire one quotient bit per
// stage. Both directions run through the same number of stages, so results always
// leave in input order. Backpressure on m_tready stalls the whole pipeline only after
// the skid register has filled.
module rgb_hsl_color_converter #(
    parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // Bits from the lowest: in_red_or_hue, in_green_or_sat, in_blue_or_light, zero pad.
    input  logic [rhc_pkg::DATA_W-1:0] s_tdata,
    // Bit 0: operation.
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // Bits from the lowest: out_red_or_hue, out_green_or_sat, out_blue_or_light, zero pad.
    output logic [rhc_pkg::DATA_W-1:0] m_tdata
);

    import rhc_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int QB   = (F + 2 > 14) ? F + 2 : 14;  // divider quotient bits
    localparam int NP   = QB + 4;                     // pipeline banks before the output
    localparam int TW   = 2 * F + 2;                  // temp1/temp2 at scale ONE*ONE
    localparam int PW   = TW + 10;
    localparam int SW   = PW + 1;
    localparam int ZW   = F + 4;
    localparam int RW   = F + 5;
    localparam int NSW  = F + 14;
    localparam int NHW  = 27;
    localparam int TOTW = 28;
    localparam logic [31:0]   ONE32 = 32'(1) << F;
    localparam logic [RW-1:0] RECIP = RW'((64'(1) << (F + 8)) / 64'd15);
    localparam logic [SW-1:0] RND   = SW'(64'(HUE_SIXTH / 2) << F);

    typedef logic [FIELD_W-1:0] fld_t;

    typedef struct packed {
        op_t  op;
        logic dz;
        fld_t lig;
        fld_t hr;
        fld_t hg;
        fld_t hb;
    } side_t;

    function automatic fld_t sat1(input fld_t v);
        fld_t r;
        r = v;
        if (32'(v) > ONE32) begin
            r = FIELD_W'(ONE32);
        end
        return r;
    endfunction

    function automatic logic signed [13:0] sdiff(input fld_t a, input fld_t b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic [9:0] kfun(input fld_t t);
        logic [9:0] k;
        if (t < FIELD_W'(HUE_SIXTH)) begin
            k = t[9:0];
        end else if (t < FIELD_W'(3 * HUE_SIXTH)) begin
            k = 10'(HUE_SIXTH);
        end else if (t < FIELD_W'(4 * HUE_SIXTH)) begin
            k = 10'(FIELD_W'(4 * HUE_SIXTH) - t);
        end else begin
            k = '0;
        end
        return k;
    endfunction

    // Global stall: the pipeline moves whenever the skid register is empty.
    logic en;
    logic [NP-1:0] vld_reg;

    // Bank 0: clamped inputs.
    op_t  b0_op_reg;
    fld_t b0_x0_reg, b0_x1_reg, b0_x2_reg;
    logic b0_grey_reg;
    fld_t ir, ig, ib, x0_next;
    op_t  op_in;

    // Bank 1: max, min and hue sector, or the product L*S.
    op_t  b1_op_reg;
    fld_t b1_mx_reg, b1_mn_reg, b1_x0_reg, b1_x1_reg, b1_x2_reg;
    sec_t b1_sec_reg, sec_next;
    logic signed [13:0] b1_hd_reg, hd_next;
    logic [2*FIELD_W-1:0] b1_ls_reg;
    logic b1_grey_reg;
    fld_t mx_next, mn_next;

    // Bank 2: difference, denominator, lightness and hue numerator, or temp1/temp2.
    op_t  b2_op_reg;
    fld_t b2_d_reg, b2_lig_reg, b2_x2_reg;
    logic [DIV_W-1:0] b2_den_reg;
    logic signed [TOTW-1:0] b2_tot_reg;
    logic [TW-1:0] b2_t1_reg, b2_t2_reg;
    fld_t b2_tr_reg, b2_tg_reg, b2_tb_reg;
    logic b2_grey_reg;
    fld_t d_c, lig_c, tr_c, tb_c;
    logic [DIV_W-1:0] sum_c, den_c;
    logic signed [TOTW-1:0] tot_c, hd_ext, offd;
    logic [11:0] off_c;
    logic [TW-1:0] lone, sone, lsx, t1_c;
    logic [DIV_W:0] hx;

    // Bank 3: divider operands, or ramp weights.
    op_t  b3_op_reg;
    logic b3_dz_reg, b3_grey_reg;
    fld_t b3_lig_reg, b3_l_reg;
    logic [NSW-1:0] b3_nums_reg;
    logic [NHW-1:0] b3_numh_reg;
    logic [DIV_W-1:0] b3_den_reg, b3_dv_reg;
    logic [TW-1:0] b3_diff_reg, b3_t2_reg;
    logic [9:0] b3_k_reg [3];
    logic signed [TOTW-1:0] tw_c;

    // Banks 4 to 7: HSL channel arithmetic, one lane per channel.
    logic [PW-1:0] b4_prod_reg [3];
    logic [PW-1:0] b4_base_reg;
    logic b4_grey_reg, b5_grey_reg, b6_grey_reg;
    fld_t b4_l_reg, b5_l_reg, b6_l_reg;
    logic [ZW-1:0] b5_z_reg [3];
    logic [ZW-1:0] b6_z_reg [3];
    logic [ZW-1:0] b6_q_reg [3];
    fld_t b7_ch_reg [3];
    logic [ZW-1:0] z_next [3];
    logic [ZW-1:0] q_next [3];
    fld_t ch_next [3];

    side_t sb_reg [QB];
    logic [QB-1:0] qs, qh;

    // Output register and skid.
    logic out_vld_reg, skid_vld_reg, take;
    logic [DATA_W-1:0] out_data_reg, skid_data_reg, fin;
    logic [QB:0] hq, sq;
    logic [QB-1:0] hr;
    fld_t hue_f, sat_f;

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign take     = en && vld_reg[NP-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NP-2:0], s_tvalid};
        end
    end

    // Bank 0 logic: saturate channels, reduce the hue below one turn.
    always_comb begin
        op_in = op_t'(s_tuser);
        ir    = s_tdata[FIELD_W-1:0];
        ig    = s_tdata[2*FIELD_W-1:FIELD_W];
        ib    = s_tdata[3*FIELD_W-1:2*FIELD_W];
        if (op_in == OP_RGB2HSL) begin
            x0_next = sat1(ir);
        end else if (ir >= FIELD_W'(HUE_TURN)) begin
            x0_next = ir - FIELD_W'(HUE_TURN);
        end else begin
            x0_next = ir;
        end
    end

    // Bank 1 logic.
    always_comb begin
        mx_next = (b0_x0_reg > b0_x1_reg) ? b0_x0_reg : b0_x1_reg;
        if (b0_x2_reg > mx_next) begin
            mx_next = b0_x2_reg;
        end
        mn_next = (b0_x0_reg < b0_x1_reg) ? b0_x0_reg : b0_x1_reg;
        if (b0_x2_reg < mn_next) begin
            mn_next = b0_x2_reg;
        end
        // Ties fall through to the blue sector.
        if (b0_x0_reg > b0_x1_reg && b0_x0_reg > b0_x2_reg) begin
            sec_next = SEC_RED;
            hd_next  = sdiff(b0_x1_reg, b0_x2_reg);
        end else if (b0_x1_reg > b0_x0_reg && b0_x1_reg > b0_x2_reg) begin
            sec_next = SEC_GREEN;
            hd_next  = sdiff(b0_x2_reg, b0_x0_reg);
        end else begin
            sec_next = SEC_BLUE;
            hd_next  = sdiff(b0_x0_reg, b0_x1_reg);
        end
    end

    // Bank 2 logic.
    always_comb begin
        d_c   = b1_mx_reg - b1_mn_reg;
        sum_c = {1'b0, b1_mx_reg} + {1'b0, b1_mn_reg};
        if (32'(sum_c) <= ONE32) begin
            den_c = sum_c;
        end else begin
            den_c = DIV_W'((ONE32 << 1) - 32'(sum_c));
        end
        lig_c = FIELD_W'(((DIV_W + 1)'(sum_c) + 1'b1) >> 1);
        case (b1_sec_reg)
            SEC_RED:   off_c = 12'd0;
            SEC_GREEN: off_c = 12'(2 * HUE_SIXTH);
            default:   off_c = 12'(4 * HUE_SIXTH);
        endcase
        hd_ext = TOTW'(b1_hd_reg);
        offd   = $signed(TOTW'(32'(off_c) * 32'(d_c)));
        tot_c  = hd_ext * $signed(TOTW'(HUE_SIXTH)) + offd;

        // HSL side: x0 is hue, x1 saturation, x2 lightness.
        lone = TW'(b1_x2_reg) << F;
        sone = TW'(b1_x1_reg) << F;
        lsx  = TW'(b1_ls_reg);
        if ((32'(b1_x2_reg) << 1) < ONE32) begin
            t1_c = lone + lsx;
        end else begin
            t1_c = lone + sone - lsx;
        end
        hx = (DIV_W + 1)'(b1_x0_reg) + (DIV_W + 1)'(2 * HUE_SIXTH);
        if (hx >= (DIV_W + 1)'(HUE_TURN)) begin
            tr_c = FIELD_W'(hx - (DIV_W + 1)'(HUE_TURN));
        end else begin
            tr_c = FIELD_W'(hx);
        end
        if (b1_x0_reg >= FIELD_W'(2 * HUE_SIXTH)) begin
            tb_c = b1_x0_reg - FIELD_W'(2 * HUE_SIXTH);
        end else begin
            tb_c = b1_x0_reg + FIELD_W'(4 * HUE_SIXTH);
        end
    end

    // Bank 3 logic: a negative hue numerator wraps by one full turn.
    always_comb begin
        if (b2_tot_reg < 0) begin
            tw_c = b2_tot_reg + $signed(TOTW'(32'(HUE_TURN) * 32'(b2_d_reg)));
        end else begin
            tw_c = b2_tot_reg;
        end
    end

    // Banks 5 to 7: round, divide by 960 * ONE, fix the reciprocal estimate; grey uses L.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            z_next[c]  = ZW'((SW'(b4_base_reg) + SW'(b4_prod_reg[c]) + RND) >> (F + 6));
            q_next[c]  = ZW'(((ZW + RW)'(b5_z_reg[c]) * (ZW + RW)'(RECIP)) >> (F + 8));
            ch_next[c] = FIELD_W'(b6_q_reg[c]);
            if (b6_z_reg[c] - ZW'(b6_q_reg[c] * ZW'(15)) >= ZW'(15)) begin
                ch_next[c] = FIELD_W'(b6_q_reg[c] + 1'b1);
            end
            if (b6_grey_reg) begin
                ch_next[c] = b6_l_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b0_op_reg   <= op_in;
            b0_x0_reg   <= x0_next;
            b0_x1_reg   <= sat1(ig);
            b0_x2_reg   <= sat1(ib);
            b0_grey_reg <= (ig == '0);

            b1_op_reg   <= b0_op_reg;
            b1_mx_reg   <= mx_next;
            b1_mn_reg   <= mn_next;
            b1_sec_reg  <= sec_next;
            b1_hd_reg   <= hd_next;
            b1_ls_reg   <= b0_x2_reg * b0_x1_reg;
            b1_x0_reg   <= b0_x0_reg;
            b1_x1_reg   <= b0_x1_reg;
            b1_x2_reg   <= b0_x2_reg;
            b1_grey_reg <= b0_grey_reg;

            b2_op_reg   <= b1_op_reg;
            b2_d_reg    <= d_c;
            b2_den_reg  <= den_c;
            b2_lig_reg  <= lig_c;
            b2_tot_reg  <= tot_c;
            b2_t1_reg   <= t1_c;
            b2_t2_reg   <= (lone << 1) - t1_c;
            b2_tr_reg   <= tr_c;
            b2_tg_reg   <= b1_x0_reg;
            b2_tb_reg   <= tb_c;
            b2_x2_reg   <= b1_x2_reg;
            b2_grey_reg <= b1_grey_reg;

            b3_op_reg   <= b2_op_reg;
            b3_dz_reg   <= (b2_d_reg == '0);
            b3_lig_reg  <= b2_lig_reg;
            b3_nums_reg <= NSW'(b2_d_reg) << (F + 1);
            b3_numh_reg <= NHW'(tw_c) << 1;
            b3_den_reg  <= b2_den_reg;
            b3_dv_reg   <= DIV_W'(b2_d_reg);
            b3_diff_reg <= b2_t1_reg - b2_t2_reg;
            b3_t2_reg   <= b2_t2_reg;
            b3_k_reg[0] <= kfun(b2_tr_reg);
            b3_k_reg[1] <= kfun(b2_tg_reg);
            b3_k_reg[2] <= kfun(b2_tb_reg);
            b3_l_reg    <= b2_x2_reg;
            b3_grey_reg <= b2_grey_reg;

            for (int c = 0; c < 3; c++) begin
                b4_prod_reg[c] <= PW'(b3_diff_reg) * PW'(b3_k_reg[c]);
                b5_z_reg[c]    <= z_next[c];
                b6_z_reg[c]    <= b5_z_reg[c];
                b6_q_reg[c]    <= q_next[c];
                b7_ch_reg[c]   <= ch_next[c];
            end
            b4_base_reg <= PW'(b3_t2_reg) * PW'(HUE_SIXTH);
            b4_grey_reg <= b3_grey_reg;
            b5_grey_reg <= b4_grey_reg;
            b6_grey_reg <= b5_grey_reg;
            b4_l_reg    <= b3_l_reg;
            b5_l_reg    <= b4_l_reg;
            b6_l_reg    <= b5_l_reg;

            // Side band runs beside the dividers; HSL results join once they are done.
            sb_reg[0] <= '{op: b3_op_reg, dz: b3_dz_reg, lig: b3_lig_reg,
                           hr: '0, hg: '0, hb: '0};
            for (int i = 1; i < QB; i++) begin
                if (i == 4) begin
                    sb_reg[i] <= '{op: sb_reg[i-1].op, dz: sb_reg[i-1].dz,
                                   lig: sb_reg[i-1].lig, hr: b7_ch_reg[0],
                                   hg: b7_ch_reg[1], hb: b7_ch_reg[2]};
                end else begin
                    sb_reg[i] <= sb_reg[i-1];
                end
            end
        end
    end

    rhc_div #(
        .NW (NSW),
        .DB (DIV_W),
        .QB (QB)
    ) u_sat_div (
        .aclk (aclk),
        .en   (en),
        .num  (b3_nums_reg),
        .den  (b3_den_reg),
        .quo  (qs)
    );

    rhc_div #(
        .NW (NHW),
        .DB (DIV_W),
        .QB (QB)
    ) u_hue_div (
        .aclk (aclk),
        .en   (en),
        .num  (b3_numh_reg),
        .den  (b3_dv_reg),
        .quo  (qh)
    );

    // The dividers produce twice the quotient; adding one and halving rounds it.
    always_comb begin
        hq = (QB + 1)'(qh) + 1'b1;
        sq = (QB + 1)'(qs) + 1'b1;
        hr = QB'(hq >> 1);
        if (hr >= QB'(HUE_TURN)) begin
            hr = hr - QB'(HUE_TURN);
        end
        hue_f = FIELD_W'(hr);
        sat_f = FIELD_W'(sq >> 1);
        if (sb_reg[QB-1].dz) begin
            hue_f = '0;
            sat_f = '0;
        end
        if (sb_reg[QB-1].op == OP_RGB2HSL) begin
            fin = {1'b0, sb_reg[QB-1].lig, sat_f, hue_f};
        end else begin
            fin = {1'b0, sb_reg[QB-1].hb, sb_reg[QB-1].hg, sb_reg[QB-1].hr};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= take;
            end
        end else if (take) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_tready) begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : fin;
        end else if (take) begin
            skid_data_reg <= fin;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// File: sv/rhc_div.sv
// Pipelined restoring divider that retires one quotient bit per register stage.
`default_nettype none
module rhc_div #(
    parameter int NW = 27,
    parameter int DB = 14,
    parameter int QB = 14
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DB-1:0] den,
    output logic [QB-1:0] quo
);

    localparam int XW = QB + DB;

    logic [XW-1:0] num_x;
    logic [DB-1:0] rem_reg [QB-1];
    logic [DB-1:0] rem_next [QB-1];
    logic [DB-1:0] dv_reg [QB-1];
    logic [QB-1:0] lo_reg [QB-1];
    logic [QB-1:0] lo_next [QB-1];
    logic [QB-1:0] q_reg [QB];
    logic [QB-1:0] q_next [QB];

    assign num_x = XW'(num);

    generate
        for (genvar i = 0; i < QB; i++) begin : g_step
            logic [DB-1:0] rem_in;
            logic [DB-1:0] dv_in;
            logic [QB-1:0] lo_in;
            logic [QB-1:0] q_in;
            logic [DB:0]   trial;
            logic          ge;

            if (i == 0) begin : g_first
                // The quotient bound keeps the upper part below the divisor.
                assign rem_in = num_x[XW-1:QB];
                assign lo_in  = num_x[QB-1:0];
                assign q_in   = '0;
                assign dv_in  = den;
            end else begin : g_next
                assign rem_in = rem_reg[i-1];
                assign lo_in  = lo_reg[i-1];
                assign q_in   = q_reg[i-1];
                assign dv_in  = dv_reg[i-1];
            end

            always_comb begin
                trial     = {rem_in, lo_in[QB-1]};
                ge        = (trial >= {1'b0, dv_in});
                q_next[i] = {q_in[QB-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[i] <= q_next[i];
                end
            end

            if (i < QB - 1) begin : g_carry
                always_comb begin
                    rem_next[i] = ge ? DB'(trial - {1'b0, dv_in}) : DB'(trial);
                    lo_next[i]  = lo_in << 1;
                end

                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[i] <= rem_next[i];
                        lo_reg[i]  <= lo_next[i];
                        dv_reg[i]  <= dv_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = q_reg[QB-1];

endmodule
`default_nettype wire

// File: test/rgb_hsl_color_converter_checker.sv
`timescale 1ns / 100ps
// Checker for the RGB/HSL color converter: watches both channels, predicts and compares.
module rgb_hsl_color_converter_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [rhc_pkg::DATA_W-1:0] s_tdata,
    input  logic                       s_tuser,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [rhc_pkg::DATA_W-1:0] m_tdata,
    output int                         fail_count,
    output int                         pending_colors,
    output int                         colors_checked
);
    import rhc_pkg::*;

    localparam longint ONE = 64'd1 << FRAC_BITS_DEF;

    typedef struct packed {
        logic [FIELD_W-1:0] light_or_blue;
        logic [FIELD_W-1:0] sat_or_green;
        logic [FIELD_W-1:0] hue_or_red;
    } color_t;

    color_t expected_colors[$];

    function automatic longint clamp_one(longint v);
        return v > ONE ? ONE : v;
    endfunction

    function automatic longint ramp_channel(longint t1s, longint t2s, longint t);
        longint k;
        longint den;
        if (t < HUE_SIXTH) k = t;
        else if (t < 3 * HUE_SIXTH) k = HUE_SIXTH;
        else if (t < 4 * HUE_SIXTH) k = 4 * HUE_SIXTH - t;
        else k = 0;
        den = HUE_SIXTH * ONE;
        return (t2s * HUE_SIXTH + (t1s - t2s) * k + den / 2) / den;
    endfunction

    function automatic color_t convert_color(op_t op, longint a, longint b, longint c);
        color_t res;
        longint r, g, bl, mx, mn, sum, d, den, hue, sat, t1s, t2s, tr, tb, total;
        if (op == OP_RGB2HSL) begin
            r = clamp_one(a);
            g = clamp_one(b);
            bl = clamp_one(c);
            mx = (r > g) ? r : g;
            if (bl > mx) mx = bl;
            mn = (r < g) ? r : g;
            if (bl < mn) mn = bl;
            sum = mx + mn;
            d = mx - mn;
            hue = 0;
            sat = 0;
            if (d != 0) begin
                den = (sum <= ONE) ? sum : 2 * ONE - sum;
                sat = (2 * d * ONE + den) / (2 * den);
                // Ties between channels fall through to the blue sector.
                if (r > g && r > bl) total = HUE_SIXTH * (g - bl);
                else if (g > r && g > bl) total = 2 * HUE_SIXTH * d + HUE_SIXTH * (bl - r);
                else total = 4 * HUE_SIXTH * d + HUE_SIXTH * (r - g);
                if (total < 0) total += HUE_TURN * d;
                hue = (2 * total + d) / (2 * d);
                if (hue >= HUE_TURN) hue -= HUE_TURN;
            end
            res.hue_or_red = hue[FIELD_W-1:0];
            res.sat_or_green = sat[FIELD_W-1:0];
            res.light_or_blue = FIELD_W'((sum + 1) >> 1);
        end else begin
            c = clamp_one(c);
            if (b == 0) begin
                res = '{c[FIELD_W-1:0], c[FIELD_W-1:0], c[FIELD_W-1:0]};
            end else begin
                b = clamp_one(b);
                if (a >= HUE_TURN) a -= HUE_TURN;
                if (2 * c < ONE) t1s = c * (ONE + b);
                else t1s = (c + b) * ONE - c * b;
                t2s = 2 * c * ONE - t1s;
                tr = a + 2 * HUE_SIXTH;
                if (tr >= HUE_TURN) tr -= HUE_TURN;
                tb = (a >= 2 * HUE_SIXTH) ? a - 2 * HUE_SIXTH : a + HUE_TURN - 2 * HUE_SIXTH;
                res.hue_or_red = FIELD_W'(ramp_channel(t1s, t2s, tr));
                res.sat_or_green = FIELD_W'(ramp_channel(t1s, t2s, a));
                res.light_or_blue = FIELD_W'(ramp_channel(t1s, t2s, tb));
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        color_t want;
        color_t got;
        if (aresetn && s_tvalid && s_tready)
            expected_colors.insert(expected_colors.size(), convert_color(op_t'(s_tuser),
                longint'(s_tdata[FIELD_W-1:0]), longint'(s_tdata[2*FIELD_W-1:FIELD_W]),
                longint'(s_tdata[3*FIELD_W-1:2*FIELD_W])));
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[3*FIELD_W-1:0];
            colors_checked <= colors_checked + 1;
            if (expected_colors.size() == 0) begin
                $display("%0t: result beat %h arrived with nothing expected", $time, got);
                fail_count <= fail_count + 1;
            end else begin
                want = expected_colors.pop_front();
                if (want !== got || m_tdata[DATA_W-1:3*FIELD_W] !== '0) begin
                    $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d pad %h",
                        $time, want.hue_or_red, want.sat_or_green, want.light_or_blue,
                        got.hue_or_red, got.sat_or_green, got.light_or_blue,
                        m_tdata[DATA_W-1:3*FIELD_W]);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // Sampled after the queue settles so the top sees a stable count.
    always @(negedge aclk) pending_colors = expected_colors.size();

    initial begin
        fail_count = 0;
        colors_checked = 0;
        pending_colors = 0;
    end
endmodule

// File: test/rgb_hsl_color_converter_tb.sv
`timescale 1ns / 100ps
// Testbench top for the RGB/HSL color converter: stimulus, stalls and verdict.
module rgb_hsl_color_converter_tb;
    import rhc_pkg::*;

    localparam int RANDOM_BEATS = 550;
    localparam int STALL_LIMIT  = 5000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;
    int                  fail_count;
    int                  pending_colors;
    int                  colors_checked;
    int                  idle_cycles;
    int                  hsl_beats;
    int                  rgb_beats;

    rgb_hsl_color_converter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    rgb_hsl_color_converter_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_colors(pending_colors),
        .colors_checked(colors_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one, and stretches of none at all.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sink side stalls independently of the source.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Watchdog: any cycle with no accepted beat on either side counts toward the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Presents one beat, holds it until accepted, then maybe idles.
    task automatic send_color(op_t op, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                              logic [FIELD_W-1:0] c);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(DATA_W - 3 * FIELD_W){1'b0}}, c, b, a};
        if (op == OP_HSL2RGB) hsl_beats++;
        else rgb_beats++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [FIELD_W-1:0] rand_level();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return FIELD_W'($urandom_range(4097, 8191));
        if (roll == 1) return $urandom_range(0, 1) ? 13'd4096 : 13'd0;
        return FIELD_W'($urandom_range(0, 4096));
    endfunction

    initial begin
        logic [FIELD_W-1:0] v;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        idle_cycles = 0;
        hsl_beats = 0;
        rgb_beats = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: grey, primaries, channel ties, overrange channels, a hue near a full
        // turn that rounds up to it, and the wide corners of the HSL side.
        send_color(OP_RGB2HSL, 13'd0, 13'd0, 13'd0);
        send_color(OP_RGB2HSL, 13'd4096, 13'd4096, 13'd4096);
        send_color(OP_RGB2HSL, 13'd2000, 13'd2000, 13'd2000);
        send_color(OP_RGB2HSL, 13'd4096, 13'd0, 13'd0);
        send_color(OP_RGB2HSL, 13'd0, 13'd4096, 13'd0);
        send_color(OP_RGB2HSL, 13'd0, 13'd0, 13'd4096);
        send_color(OP_RGB2HSL, 13'd4096, 13'd4096, 13'd0);
        send_color(OP_RGB2HSL, 13'd0, 13'd4096, 13'd4096);
        send_color(OP_RGB2HSL, 13'd4096, 13'd0, 13'd4096);
        send_color(OP_RGB2HSL, 13'd8191, 13'd8191, 13'd100);
        send_color(OP_RGB2HSL, 13'd8191, 13'd0, 13'd5000);
        send_color(OP_RGB2HSL, 13'd4096, 13'd0, 13'd1);
        send_color(OP_RGB2HSL, 13'd4000, 13'd1, 13'd3);
        send_color(OP_HSL2RGB, 13'd1000, 13'd0, 13'd2048);
        send_color(OP_HSL2RGB, 13'd0, 13'd4096, 13'd2048);
        send_color(OP_HSL2RGB, 13'd5759, 13'd8191, 13'd4096);
        send_color(OP_HSL2RGB, 13'd8191, 13'd4096, 13'd1000);
        send_color(OP_HSL2RGB, 13'd5760, 13'd3000, 13'd8191);
        send_color(OP_HSL2RGB, 13'd960, 13'd4096, 13'd0);
        send_color(OP_HSL2RGB, 13'd2880, 13'd2048, 13'd2047);
        send_color(OP_HSL2RGB, 13'd3840, 13'd1, 13'd3000);
        send_color(OP_HSL2RGB, 13'd1920, 13'd8191, 13'd8191);
        send_color(OP_HSL2RGB, 13'd4500, 13'd6000, 13'd2048);

        // Random: mostly in-range colors, with overrange fields and ties mixed in.
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if ($urandom_range(0, 1)) begin
                v = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom_range(0, 8191))
                                                : FIELD_W'($urandom_range(0, 5759));
                send_color(OP_HSL2RGB, v, rand_level(), rand_level());
            end else begin
                v = rand_level();
                if ($urandom_range(0, 5) == 0)
                    send_color(OP_RGB2HSL, v, v, rand_level());
                else
                    send_color(OP_RGB2HSL, v, rand_level(), rand_level());
            end
        end
        s_tvalid <= 1'b0;

        // Drain: the watchdog bounds this if results stop coming.
        @(negedge aclk);
        while (pending_colors != 0) @(negedge aclk);
        repeat (40) @(posedge aclk);

        $display("Converted %0d RGB-to-HSL and %0d HSL-to-RGB colors, %0d results checked,",
                 rgb_beats, hsl_beats, colors_checked);
        $display("with random source gaps and sink stalls throughout.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
